[hw/rtl/sppa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar proximity alarm package
// Widths, register reset values, register indexes and state types.
// ----------------------------------------------------------------------------
package sppa_pkg;

    localparam int unsigned TICKS_PER_MS = 1000;
    localparam int unsigned PRESC_W      = 10;
    localparam int unsigned WIDTH_BITS   = 16;
    localparam int unsigned PERIOD_W     = 9;
    localparam int unsigned PROD_W       = WIDTH_BITS + PERIOD_W;
    localparam int unsigned DIV_CNT_W    = 4;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned IN_DATA_W    = 8;
    localparam int unsigned OUT_FIELDS_W = PERIOD_W + 3;
    localparam int unsigned OUT_DATA_W   = 16;

    localparam logic [WIDTH_BITS-1:0] ALARM_MAX_RST  = WIDTH_BITS'(1550);
    localparam logic [WIDTH_BITS-1:0] ALARM_MIN_RST  = WIDTH_BITS'(500);
    localparam logic [PERIOD_W-1:0]   PERIOD_MAX_RST = PERIOD_W'(300);
    localparam logic [PERIOD_W-1:0]   PERIOD_MIN_RST = PERIOD_W'(50);
    localparam logic [PERIOD_W-1:0]   BEEP_ON_RST    = PERIOD_W'(50);
    localparam logic [15:0]           DWELL_RST      = 16'd5000;
    localparam logic [WIDTH_BITS-1:0] REG_WIDTH_RST  = WIDTH_BITS'(700);

    localparam logic [DIV_CNT_W-1:0]  DIV_LAST_BIT   = DIV_CNT_W'(PERIOD_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_MAX  = 3'd0,
        CFG_ALARM_MIN  = 3'd1,
        CFG_PERIOD_MAX = 3'd2,
        CFG_PERIOD_MIN = 3'd3,
        CFG_BEEP_ON    = 3'd4,
        CFG_DWELL      = 3'd5,
        CFG_REG_WIDTH  = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_MUL,
        ST_DIV,
        ST_MAP,
        ST_BEEP
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ON     = 2'd1,
        PH_SILENT = 2'd2
    } phase_t;

endpackage

[hw/rtl/sonar_pulse_proximity_alarm_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar pulse proximity alarm
// Measures sonar PWM pulse width per microsecond tick, flags a near obstacle,
// maps the width into a beep period with a shift-subtract divider,
// raises a register event after a very-close dwell and runs the buzzer.
//
//   channel   | dir | payload
//   ----------+-----+---------------------------------------------------
//   s_axis    | in  | tdata[0] sonar_level
//   m_axis    | out | tdata buzzer_on, obstacle_near, register_event,
//             |     |       repeat_period_ms
//   cfg       | in  | cfg_we, cfg_index, cfg_data (write only)
//
// Each beat passes the idle, tick and beep states; a falling edge that needs the
// period map also passes a multiply step, 9 divider iterations and a map step.
// The divider loop sets the worst case. Reset clears all control state and
// loads the register defaults. A stalled result holds in the output register;
// the next beat is still taken and waits in the final step for it to drain.
// ----------------------------------------------------------------------------
module sonar_pulse_proximity_alarm_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sppa_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [0] sonar_level
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] buzzer_on, [1] obstacle_near, [2] register_event, [11:3] repeat_period_ms
    output logic [sppa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [sppa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sppa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sppa_pkg::*;

    // configuration
    logic [WIDTH_BITS-1:0] alarm_max_reg;
    logic [WIDTH_BITS-1:0] alarm_min_reg;
    logic [PERIOD_W-1:0]   period_max_reg;
    logic [PERIOD_W-1:0]   period_min_reg;
    logic [PERIOD_W-1:0]   beep_on_reg;
    logic [15:0]           dwell_cfg_reg;
    logic [WIDTH_BITS-1:0] reg_width_reg;

    // control state
    state_t                state_reg,       state_next;
    logic                  level_reg,       level_next;
    logic                  prev_reg,        prev_next;
    logic [WIDTH_BITS-1:0] pulse_reg,       pulse_next;
    logic [PRESC_W-1:0]    presc_reg,       presc_next;
    logic                  ms_tick_reg,     ms_tick_next;
    logic                  near_reg,        near_next;
    logic [PERIOD_W-1:0]   rep_reg,         rep_next;
    logic                  dwell_act_reg,   dwell_act_next;
    logic [15:0]           dwell_cnt_reg,   dwell_cnt_next;
    logic                  event_reg,       event_next;
    phase_t                phase_reg,       phase_next;
    logic [PERIOD_W-1:0]   beep_cnt_reg,    beep_cnt_next;
    logic [PERIOD_W-1:0]   silence_reg,     silence_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg,     div_cnt_next;
    logic                  out_valid_reg,   out_valid_next;

    // datapath
    logic [WIDTH_BITS-1:0]   diff_reg,      diff_next;
    logic [WIDTH_BITS-1:0]   den_reg,       den_next;
    logic                    neg_reg,       neg_next;
    logic [PROD_W-1:0]       rem_reg,       rem_next;
    logic [PERIOD_W-1:0]     quo_reg,       quo_next;
    logic [OUT_FIELDS_W-1:0] out_data_reg,  out_data_next;

    logic                    presc_wrap;
    logic [15:0]             dwell_cnt_v;
    logic [PERIOD_W:0]       dp;
    logic [PERIOD_W-1:0]     dp_mag;
    logic [PROD_W-1:0]       den_sh;
    logic                    take;
    logic [PERIOD_W:0]       map_sum;
    logic [PERIOD_W-1:0]     beep_inc;
    logic                    buzz;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_data_reg};

    assign presc_wrap = (32'(presc_reg) + 32'd1 >= TICKS_PER_MS);
    assign dp         = {1'b0, period_max_reg} - {1'b0, period_min_reg};
    assign dp_mag     = dp[PERIOD_W] ? PERIOD_W'(-dp) : dp[PERIOD_W-1:0];
    assign den_sh     = PROD_W'(den_reg) << div_cnt_reg;
    assign take       = (rem_reg >= den_sh);
    assign map_sum    = neg_reg ? ({1'b0, period_min_reg} - {1'b0, quo_reg})
                                : ({1'b0, period_min_reg} + {1'b0, quo_reg});
    assign beep_inc   = (ms_tick_reg && beep_cnt_reg != '1) ? beep_cnt_reg + 1'b1
                                                            : beep_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        prev_next      = prev_reg;
        pulse_next     = pulse_reg;
        presc_next     = presc_reg;
        ms_tick_next   = ms_tick_reg;
        near_next      = near_reg;
        rep_next       = rep_reg;
        dwell_act_next = dwell_act_reg;
        dwell_cnt_next = dwell_cnt_reg;
        event_next     = event_reg;
        phase_next     = phase_reg;
        beep_cnt_next  = beep_cnt_reg;
        silence_next   = silence_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        diff_next      = diff_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_data_next  = out_data_reg;
        dwell_cnt_v    = dwell_cnt_reg;
        buzz           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    level_next = s_axis_tdata[0];
                    state_next = ST_TICK;
                end
            end

            ST_TICK:
            begin
                ms_tick_next = presc_wrap;
                presc_next   = presc_wrap ? '0 : presc_reg + 1'b1;
                if (presc_wrap && dwell_act_reg && dwell_cnt_reg != '1)
                begin
                    dwell_cnt_v = dwell_cnt_reg + 1'b1;
                end
                dwell_cnt_next = dwell_cnt_v;
                event_next     = 1'b0;
                prev_next      = level_reg;
                state_next     = ST_BEEP;

                if (level_reg && !prev_reg)
                begin
                    pulse_next = WIDTH_BITS'(1);
                end
                else if (level_reg)
                begin
                    if (pulse_reg != '1)
                    begin
                        pulse_next = pulse_reg + 1'b1;
                    end
                end
                else if (prev_reg)
                begin
                    if (pulse_reg < alarm_max_reg)
                    begin
                        if (pulse_reg < reg_width_reg)
                        begin
                            if (!dwell_act_reg)
                            begin
                                dwell_act_next = 1'b1;
                                dwell_cnt_next = '0;
                            end
                            else if (dwell_cnt_v > dwell_cfg_reg)
                            begin
                                event_next     = 1'b1;
                                dwell_act_next = 1'b0;
                            end
                        end
                        else
                        begin
                            dwell_act_next = 1'b0;
                        end
                        near_next = 1'b1;
                        if (pulse_reg < alarm_min_reg)
                        begin
                            rep_next = period_min_reg;
                        end
                        else
                        begin
                            diff_next  = pulse_reg - alarm_min_reg;
                            den_next   = alarm_max_reg - alarm_min_reg;
                            state_next = ST_MUL;
                        end
                    end
                    else
                    begin
                        dwell_act_next = 1'b0;
                        near_next      = 1'b0;
                    end
                end
            end

            ST_MUL:
            begin
                rem_next     = PROD_W'(diff_reg) * PROD_W'(dp_mag);
                neg_next     = dp[PERIOD_W];
                quo_next     = '0;
                div_cnt_next = DIV_LAST_BIT;
                state_next   = ST_DIV;
            end

            ST_DIV:
            begin
                if (take)
                begin
                    rem_next = rem_reg - den_sh;
                end
                quo_next = {quo_reg[PERIOD_W-2:0], take};
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_MAP;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end

            ST_MAP:
            begin
                rep_next   = map_sum[PERIOD_W-1:0];
                state_next = ST_BEEP;
            end

            ST_BEEP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    case (phase_reg)
                        PH_ON:
                        begin
                            beep_cnt_next = beep_inc;
                            if (beep_inc >= beep_on_reg)
                            begin
                                phase_next    = PH_SILENT;
                                beep_cnt_next = '0;
                                silence_next  = rep_reg;
                            end
                        end
                        PH_SILENT:
                        begin
                            beep_cnt_next = beep_inc;
                            if (beep_inc >= silence_reg)
                            begin
                                phase_next    = near_reg ? PH_ON : PH_IDLE;
                                beep_cnt_next = '0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            if (near_reg)
                            begin
                                phase_next    = PH_ON;
                                beep_cnt_next = '0;
                            end
                        end
                    endcase
                    buzz           = (phase_next == PH_ON);
                    out_data_next  = {rep_reg, event_reg, near_reg, buzz};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= 1'b0;
            prev_reg      <= 1'b0;
            pulse_reg     <= '0;
            presc_reg     <= '0;
            ms_tick_reg   <= 1'b0;
            near_reg      <= 1'b0;
            rep_reg       <= '0;
            dwell_act_reg <= 1'b0;
            dwell_cnt_reg <= '0;
            event_reg     <= 1'b0;
            phase_reg     <= PH_IDLE;
            beep_cnt_reg  <= '0;
            silence_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            prev_reg      <= prev_next;
            pulse_reg     <= pulse_next;
            presc_reg     <= presc_next;
            ms_tick_reg   <= ms_tick_next;
            near_reg      <= near_next;
            rep_reg       <= rep_next;
            dwell_act_reg <= dwell_act_next;
            dwell_cnt_reg <= dwell_cnt_next;
            event_reg     <= event_next;
            phase_reg     <= phase_next;
            beep_cnt_reg  <= beep_cnt_next;
            silence_reg   <= silence_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_max_reg  <= ALARM_MAX_RST;
            alarm_min_reg  <= ALARM_MIN_RST;
            period_max_reg <= PERIOD_MAX_RST;
            period_min_reg <= PERIOD_MIN_RST;
            beep_on_reg    <= BEEP_ON_RST;
            dwell_cfg_reg  <= DWELL_RST;
            reg_width_reg  <= REG_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALARM_MAX:  alarm_max_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_ALARM_MIN:  alarm_min_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_PERIOD_MAX: period_max_reg <= cfg_data[PERIOD_W-1:0];
                CFG_PERIOD_MIN: period_min_reg <= cfg_data[PERIOD_W-1:0];
                CFG_BEEP_ON:    beep_on_reg    <= cfg_data[PERIOD_W-1:0];
                CFG_DWELL:      dwell_cfg_reg  <= cfg_data[15:0];
                CFG_REG_WIDTH:  reg_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                default:        ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_event_implies_near: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[1])
        else $error("register event without near flag");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again while busy");

    a_div_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg <= DIV_LAST_BIT))
        else $error("divider count out of range");
`endif

endmodule
